// ----- hw/rtl/feedback_agc_real_macros.svh -----
// Assertion macros used by the feedback AGC controller.
`ifndef FEEDBACK_AGC_REAL_MACROS_SVH
`define FEEDBACK_AGC_REAL_MACROS_SVH

// Checks a property on every rising clock edge outside reset.
`define FAGC_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checks that a condition is followed by another one in the next cycle.
`define FAGC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/fagc_pkg.sv -----
// Package with constants, register indexes and control types of the feedback AGC.
package fagc_pkg;

    localparam int SAMPLE_WIDTH_DEF = 16;
    localparam int GAIN_WIDTH_DEF   = 24;

    localparam int GAIN_FRAC     = 16;
    localparam int LOOP_GAIN_W   = 16;
    localparam int LEVEL_W       = 15;
    localparam int INIT_GAIN_W   = 24;
    localparam int CFG_DATA_W    = 24;
    localparam int CFG_IDX_W     = 2;

    localparam logic [CFG_IDX_W-1:0] REG_LOOP_GAIN    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DESIRED_LEVEL = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_INITIAL_GAIN = 2'd2;

    localparam logic [LOOP_GAIN_W-1:0] LOOP_GAIN_RST    = 16'd655;
    localparam logic [LEVEL_W-1:0]     LEVEL_RST        = 15'd20861;
    localparam logic [INIT_GAIN_W-1:0] INIT_GAIN_RST    = 24'd65536;

    typedef struct packed {
        logic load_in;
        logic mul1;
        logic sat;
        logic mul2;
        logic upd;
    } t_cmd;

endpackage

// ----- hw/rtl/feedback_agc_real.sv -----
// An accepted item passes the states S_MUL1, S_SAT, S_MUL2 and S_UPD; its result is registered in S_UPD.
// The gain feedback (scale multiply, saturate, adapt multiply, gain update) runs
// through one shared datapath in four steps.
// The next item is taken in the update cycle unless a finished result still waits.
// Reset (synchronous, active low) restores register defaults and a gain of 1.0.
// Top level of the feedback AGC: controller and datapath.
module feedback_agc_real #(
    parameter int SAMPLE_WIDTH = fagc_pkg::SAMPLE_WIDTH_DEF,
    parameter int GAIN_WIDTH   = fagc_pkg::GAIN_WIDTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [fagc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [fagc_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic signed [SAMPLE_WIDTH-1:0]  i_sample,
    input  logic                            i_reload,
    input  logic                            i_last_in_block,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic signed [SAMPLE_WIDTH-1:0]  o_scaled_sample,
    output logic [GAIN_WIDTH-1:0]           o_current_gain,
    output logic                            o_clipped,
    output logic                            o_last_in_block_res
);

    fagc_pkg::t_cmd w_cmd;

    fagc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (w_cmd)
    );

    fagc_dp #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .GAIN_WIDTH   (GAIN_WIDTH)
    ) u_dp (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cmd               (w_cmd),
        .i_cfg_we            (i_cfg_we),
        .i_cfg_index         (i_cfg_index),
        .i_cfg_data          (i_cfg_data),
        .i_sample            (i_sample),
        .i_reload            (i_reload),
        .i_last_in_block     (i_last_in_block),
        .o_scaled_sample     (o_scaled_sample),
        .o_current_gain      (o_current_gain),
        .o_clipped           (o_clipped),
        .o_last_in_block_res (o_last_in_block_res)
    );

endmodule

// ----- hw/rtl/fagc_ctrl.sv -----
// Controller state machine that sequences the scale and adapt steps of the AGC.
`include "feedback_agc_real_macros.svh"

module fagc_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output fagc_pkg::t_cmd o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL1,
        S_SAT,
        S_MUL2,
        S_UPD
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   w_out_free;
    logic   w_ready;
    logic   w_accept;

    assign w_out_free = !r_out_valid || !i_out_stall;
    // A new item may enter while the previous one writes its result.
    assign w_ready    = (r_state == S_IDLE) || ((r_state == S_UPD) && w_out_free);
    assign w_accept   = i_in_valid && w_ready;

    always_comb begin
        o_cmd.load_in = w_accept;
        o_cmd.mul1    = (r_state == S_MUL1);
        o_cmd.sat     = (r_state == S_SAT);
        o_cmd.mul2    = (r_state == S_MUL2);
        o_cmd.upd     = (r_state == S_UPD) && w_out_free;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) n_state = S_MUL1;
            end
            S_MUL1: n_state = S_SAT;
            S_SAT:  n_state = S_MUL2;
            S_MUL2: n_state = S_UPD;
            S_UPD: begin
                if (w_out_free) n_state = w_accept ? S_MUL1 : S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.upd) n_out_valid = 1'b1;
        else if (!i_out_stall) n_out_valid = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = !w_ready;
    assign o_out_valid = r_out_valid;

    `FAGC_ASSERT_NEXT(a_accept_starts, i_clk, i_rst_n, w_accept, r_state == S_MUL1,
        "accepted item did not start the scale multiply")
    `FAGC_ASSERT_NEXT(a_upd_holds, i_clk, i_rst_n, (r_state == S_UPD) && !w_out_free,
        r_state == S_UPD, "finished item left update while output slot was full")
    `FAGC_ASSERT(a_valid_from_upd, i_clk, i_rst_n,
        $rose(r_out_valid) |-> $past(r_state == S_UPD), "result appeared outside update")

endmodule

// ----- hw/rtl/fagc_dp.sv -----
// Datapath of the AGC: configuration registers, gain state, multiplies and output register.
module fagc_dp #(
    parameter int SAMPLE_WIDTH = fagc_pkg::SAMPLE_WIDTH_DEF,
    parameter int GAIN_WIDTH   = fagc_pkg::GAIN_WIDTH_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  fagc_pkg::t_cmd                          i_cmd,
    input  logic                                   i_cfg_we,
    input  logic [fagc_pkg::CFG_IDX_W-1:0]          i_cfg_index,
    input  logic [fagc_pkg::CFG_DATA_W-1:0]         i_cfg_data,
    input  logic signed [SAMPLE_WIDTH-1:0]          i_sample,
    input  logic                                   i_reload,
    input  logic                                   i_last_in_block,
    output logic signed [SAMPLE_WIDTH-1:0]          o_scaled_sample,
    output logic [GAIN_WIDTH-1:0]                   o_current_gain,
    output logic                                   o_clipped,
    output logic                                   o_last_in_block_res
);

    localparam int PROD1_W = SAMPLE_WIDTH + GAIN_WIDTH + 1;
    localparam int ERR_W   = ((SAMPLE_WIDTH > fagc_pkg::LEVEL_W) ?
                              SAMPLE_WIDTH : fagc_pkg::LEVEL_W) + 1;
    localparam int PROD2_W = ERR_W + fagc_pkg::LOOP_GAIN_W + 1;
    localparam int SUM_W   = ((GAIN_WIDTH > PROD2_W) ? GAIN_WIDTH : PROD2_W) + 2;

    localparam logic signed [SAMPLE_WIDTH-1:0] SMAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
    localparam logic signed [SAMPLE_WIDTH-1:0] SMIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
    localparam logic [GAIN_WIDTH-1:0]          GMAX = {GAIN_WIDTH{1'b1}};

    // Configuration registers.
    logic [fagc_pkg::LOOP_GAIN_W-1:0] r_loop_gain;
    logic [fagc_pkg::LEVEL_W-1:0]     r_level;
    logic [fagc_pkg::INIT_GAIN_W-1:0] r_init_gain;

    // Gain state and pipeline registers.
    logic [GAIN_WIDTH-1:0]           r_gain;
    logic signed [SAMPLE_WIDTH-1:0]  r_sample;
    logic                            r_reload;
    logic                            r_last;
    logic signed [PROD1_W-1:0]       r_prod1;
    logic signed [SAMPLE_WIDTH-1:0]  r_y;
    logic                            r_clip;
    logic signed [ERR_W-1:0]         r_err;
    logic signed [PROD2_W-1:0]       r_prod2;

    logic signed [SAMPLE_WIDTH-1:0]  r_o_sample;
    logic [GAIN_WIDTH-1:0]           r_o_gain;
    logic                            r_o_clip;
    logic                            r_o_last;

    logic [GAIN_WIDTH-1:0]           w_gain_eff;
    logic signed [PROD1_W-1:0]       w_prod1;
    logic signed [PROD1_W-1:0]       w_shift;
    logic signed [SAMPLE_WIDTH-1:0]  w_y;
    logic                            w_clip;
    logic [SAMPLE_WIDTH-1:0]         w_yu;
    logic [SAMPLE_WIDTH-1:0]         w_abs;
    logic signed [ERR_W-1:0]         w_err;
    logic signed [PROD2_W-1:0]       w_prod2;
    logic signed [PROD2_W-1:0]       w_delta;
    logic signed [SUM_W-1:0]         w_sum;
    logic [GAIN_WIDTH-1:0]           w_new_gain;

    assign w_gain_eff = r_reload ? GAIN_WIDTH'(r_init_gain) : r_gain;
    assign w_prod1    = r_sample * $signed({1'b0, w_gain_eff});

    // Arithmetic shift floors the product, then it is clamped to the sample range.
    always_comb begin
        w_shift = r_prod1 >>> fagc_pkg::GAIN_FRAC;
        w_clip  = 1'b0;
        priority if (w_shift > PROD1_W'(SMAX)) begin
            w_y    = SMAX;
            w_clip = 1'b1;
        end else if (w_shift < PROD1_W'(SMIN)) begin
            w_y    = SMIN;
            w_clip = 1'b1;
        end else begin
            w_y = w_shift[SAMPLE_WIDTH-1:0];
        end
        w_yu  = w_y;
        // The most negative sample has magnitude 2^(SAMPLE_WIDTH-1), which fits unsigned.
        w_abs = w_yu[SAMPLE_WIDTH-1] ? (~w_yu + SAMPLE_WIDTH'(1)) : w_yu;
        w_err = $signed(ERR_W'(r_level)) - $signed(ERR_W'(w_abs));
    end

    assign w_prod2 = $signed({1'b0, r_loop_gain}) * r_err;

    always_comb begin
        w_delta = r_prod2 >>> (SAMPLE_WIDTH - 1);
        w_sum   = $signed(SUM_W'(r_gain)) + SUM_W'(w_delta);
        priority if (w_sum[SUM_W-1]) begin
            w_new_gain = '0;
        end else if ($unsigned(w_sum) > SUM_W'(GMAX)) begin
            w_new_gain = GMAX;
        end else begin
            w_new_gain = w_sum[GAIN_WIDTH-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_loop_gain <= fagc_pkg::LOOP_GAIN_RST;
            r_level     <= fagc_pkg::LEVEL_RST;
            r_init_gain <= fagc_pkg::INIT_GAIN_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                fagc_pkg::REG_LOOP_GAIN:
                    r_loop_gain <= i_cfg_data[fagc_pkg::LOOP_GAIN_W-1:0];
                fagc_pkg::REG_DESIRED_LEVEL:
                    r_level <= i_cfg_data[fagc_pkg::LEVEL_W-1:0];
                fagc_pkg::REG_INITIAL_GAIN:
                    r_init_gain <= i_cfg_data[fagc_pkg::INIT_GAIN_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain <= GAIN_WIDTH'(fagc_pkg::INIT_GAIN_RST);
        end else if (i_cmd.mul1 && r_reload) begin
            r_gain <= w_gain_eff;
        end else if (i_cmd.upd) begin
            r_gain <= w_new_gain;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_sample <= i_sample;
            r_reload <= i_reload;
            r_last   <= i_last_in_block;
        end
        if (i_cmd.mul1) begin
            r_prod1 <= w_prod1;
        end
        if (i_cmd.sat) begin
            r_y    <= w_y;
            r_clip <= w_clip;
            r_err  <= w_err;
        end
        if (i_cmd.mul2) begin
            r_prod2 <= w_prod2;
        end
        if (i_cmd.upd) begin
            r_o_sample <= r_y;
            r_o_gain   <= w_new_gain;
            r_o_clip   <= r_clip;
            r_o_last   <= r_last;
        end
    end

    assign o_scaled_sample     = r_o_sample;
    assign o_current_gain      = r_o_gain;
    assign o_clipped           = r_o_clip;
    assign o_last_in_block_res = r_o_last;

endmodule

// ----- verif/testbench.sv -----
// Self-checking testbench for the feedback AGC: directed table, random phases, scoreboard.
`timescale 1ns / 100ps

module testbench;
    import fagc_pkg::*;

    localparam int SW = SAMPLE_WIDTH_DEF;
    localparam int GW = GAIN_WIDTH_DEF;
    localparam logic signed [SW-1:0] SMP_MAX = 2 ** (SW - 1) - 1;
    localparam logic signed [SW-1:0] SMP_MIN = -(2 ** (SW - 1));
    localparam logic [GW-1:0] GAIN_MAX = {GW{1'b1}};
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
    localparam int LATENCY_SETTLE = 8;
    localparam int LONG_HOLD = 200;
    localparam int NUM_PHASES = 6;
    localparam int PHASE_ITEMS = 322;
    localparam int DIR_ROWS = 31;

    typedef struct packed {
        logic signed [SW-1:0] scaled;
        logic [GW-1:0]        gain;
        logic                 clipped;
        logic                 last;
    } agc_result_t;

    // One row of the directed table: either a register write or an item.
    typedef struct packed {
        logic                  is_cfg;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] data;
        logic signed [SW-1:0]  smp;
        logic                  reload;
        logic                  last;
        logic                  typed;
        logic signed [SW-1:0]  y;
        logic [GW-1:0]         g;
        logic                  c;
    } dir_row_t;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]   i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_data = '0;
    logic                   i_in_valid = 1'b0;
    logic                   o_in_stall;
    logic signed [SW-1:0]   i_sample = '0;
    logic                   i_reload = 1'b0;
    logic                   i_last_in_block = 1'b0;
    logic                   o_out_valid;
    logic                   i_out_stall = 1'b0;
    logic signed [SW-1:0]   o_scaled_sample;
    logic [GW-1:0]          o_current_gain;
    logic                   o_clipped;
    logic                   o_last_in_block_res;

    // Predictor state and register copies.
    logic [GW-1:0]          gain_track;
    logic [LOOP_GAIN_W-1:0] loop_gain_cfg;
    logic [LEVEL_W-1:0]     level_cfg;
    logic [INIT_GAIN_W-1:0] init_gain_cfg;

    agc_result_t expected_q[$];
    dir_row_t    dir_tab [DIR_ROWS];

    int failures = 0;
    int results_checked = 0;
    int items_sent = 0;
    int settings_used = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_req = 0;
    int hold_seen = 0;
    int hold_left = 0;

    feedback_agc_real DUT (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data),
        .i_in_valid         (i_in_valid),
        .o_in_stall         (o_in_stall),
        .i_sample           (i_sample),
        .i_reload           (i_reload),
        .i_last_in_block    (i_last_in_block),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_scaled_sample    (o_scaled_sample),
        .o_current_gain     (o_current_gain),
        .o_clipped          (o_clipped),
        .o_last_in_block_res(o_last_in_block_res)
    );

    always #10 i_clk = ~i_clk;

    // Scales one sample by the tracked gain and adapts the gain toward the target level.
    function automatic agc_result_t scale_and_adapt(input logic signed [SW-1:0] smp,
                                                     input logic reload, input logic last);
        longint s_val, g_val, prod, y, mag, err, lg, delta;
        agc_result_t r;
        if (reload)
            gain_track = init_gain_cfg;
        s_val = smp;
        g_val = gain_track;
        prod = s_val * g_val;
        // Arithmetic shift floors toward minus infinity, as the block rounds.
        y = prod >>> GAIN_FRAC;
        r.clipped = 1'b0;
        if (y > longint'(SMP_MAX)) begin
            y = SMP_MAX;
            r.clipped = 1'b1;
        end else if (y < longint'(SMP_MIN)) begin
            y = SMP_MIN;
            r.clipped = 1'b1;
        end
        mag = (y < 0) ? -y : y;
        err = level_cfg;
        err = err - mag;
        lg = loop_gain_cfg;
        delta = (lg * err) >>> (SW - 1);
        g_val = g_val + delta;
        if (g_val < 0)
            g_val = 0;
        if (g_val > longint'(GAIN_MAX))
            g_val = GAIN_MAX;
        gain_track = g_val[GW-1:0];
        r.scaled = y[SW-1:0];
        r.gain = gain_track;
        r.last = last;
        return r;
    endfunction

    function automatic dir_row_t item_row(input logic signed [SW-1:0] smp, input logic reload,
                                          input logic last);
        dir_row_t r;
        r = '0;
        r.smp = smp;
        r.reload = reload;
        r.last = last;
        return r;
    endfunction

    function automatic dir_row_t known_row(input logic signed [SW-1:0] smp, input logic reload,
                                           input logic last, input logic signed [SW-1:0] y,
                                           input logic [GW-1:0] g, input logic c);
        dir_row_t r;
        r = item_row(smp, reload, last);
        r.typed = 1'b1;
        r.y = y;
        r.g = g;
        r.c = c;
        return r;
    endfunction

    function automatic dir_row_t cfg_row(input logic [CFG_IDX_W-1:0] idx,
                                         input logic [CFG_DATA_W-1:0] data);
        dir_row_t r;
        r = '0;
        r.is_cfg = 1'b1;
        r.idx = idx;
        r.data = data;
        return r;
    endfunction

    // Offers one item and records its expectation when the block takes it.
    // Entered and left at a falling edge; valid stays high on exit.
    task automatic push_item(input logic signed [SW-1:0] smp, input logic reload,
                             input logic last, input dir_row_t known);
        agc_result_t r;
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_sample <= smp;
        i_reload <= reload;
        i_last_in_block <= last;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        r = scale_and_adapt(smp, reload, last);
        if (known.typed) begin
            r.scaled = known.y;
            r.gain = known.g;
            r.clipped = known.c;
        end
        expected_q.push_back(r);
        items_sent++;
        @(negedge i_clk);
    endtask

    // Stops offering items and waits until every expected result has come back.
    task automatic drain(input int settle);
        i_in_valid <= 1'b0;
        while (expected_q.size() != 0)
            @(posedge i_clk);
        repeat (settle) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic reg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            REG_LOOP_GAIN:     loop_gain_cfg = data[LOOP_GAIN_W-1:0];
            REG_DESIRED_LEVEL: level_cfg = data[LEVEL_W-1:0];
            REG_INITIAL_GAIN:  init_gain_cfg = data[INIT_GAIN_W-1:0];
            default: ;
        endcase
        @(negedge i_clk);
    endtask

    function automatic logic signed [SW-1:0] random_sample();
        case ($urandom_range(9))
            0: return SMP_MAX;
            1: return SMP_MIN;
            2, 3, 4: return SW'($urandom_range(0, 511)) - SW'(256);
            5, 6: return SW'($urandom_range(0, 8191)) - SW'(4096);
            default: return SW'($urandom);
        endcase
    endfunction

    // Output side: random stalls, plus a long hold-off whenever one is requested.
    always @(negedge i_clk) begin
        if (hold_left == 0 && hold_req != hold_seen) begin
            hold_seen = hold_req;
            hold_left = LONG_HOLD;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        agc_result_t want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_q.size() == 0) begin
                $error("result with no item pending: scaled_sample %0d current_gain %0d",
                       o_scaled_sample, o_current_gain);
                failures++;
            end else begin
                want = expected_q.pop_front();
                results_checked++;
                if (o_scaled_sample !== want.scaled) begin
                    $error("scaled_sample: expected %0d, got %0d", want.scaled, o_scaled_sample);
                    failures++;
                end
                if (o_current_gain !== want.gain) begin
                    $error("current_gain: expected %0d, got %0d", want.gain, o_current_gain);
                    failures++;
                end
                if (o_clipped !== want.clipped) begin
                    $error("clipped: expected %0b, got %0b", want.clipped, o_clipped);
                    failures++;
                end
                if (o_last_in_block_res !== want.last) begin
                    $error("last_in_block_res: expected %0b, got %0b", want.last,
                           o_last_in_block_res);
                    failures++;
                end
            end
        end
    end

    initial begin
        #10_000_000;
        $display("== FAIL ==");
        $finish;
    end

    initial begin
        dir_row_t none;
        none = '0;
        loop_gain_cfg = LOOP_GAIN_RST;
        level_cfg = LEVEL_RST;
        init_gain_cfg = INIT_GAIN_RST;
        gain_track = INIT_GAIN_RST;

        dir_tab = '{
            item_row(0, 1'b0, 1'b0),
            item_row(SMP_MAX, 1'b1, 1'b0),
            item_row(SMP_MIN, 1'b1, 1'b1),
            cfg_row(REG_LOOP_GAIN, 24'd0),
            // Writing the initial gain must leave the running gain alone.
            cfg_row(REG_INITIAL_GAIN, 24'hFFFFFF),
            item_row(100, 1'b0, 1'b0),
            known_row(1, 1'b1, 1'b0, 255, GAIN_MAX, 1'b0),
            known_row(SMP_MAX, 1'b0, 1'b1, SMP_MAX, GAIN_MAX, 1'b1),
            known_row(SMP_MIN, 1'b0, 1'b0, SMP_MIN, GAIN_MAX, 1'b1),
            known_row(-1, 1'b0, 1'b0, -256, GAIN_MAX, 1'b0),
            cfg_row(REG_INITIAL_GAIN, 24'd0),
            known_row(SMP_MAX, 1'b1, 1'b0, 0, 0, 1'b0),
            known_row(SMP_MIN, 1'b0, 1'b1, 0, 0, 1'b0),
            // High data bits beyond each register's width are dropped.
            cfg_row(REG_LOOP_GAIN, 24'hFFFFFF),
            cfg_row(REG_DESIRED_LEVEL, 24'hFFFFFF),
            item_row(0, 1'b1, 1'b0),
            cfg_row(REG_INITIAL_GAIN, 24'hFFFFF0),
            // The gain runs past its maximum and is clamped.
            known_row(0, 1'b1, 1'b0, 0, GAIN_MAX, 1'b0),
            known_row(0, 1'b0, 1'b1, 0, GAIN_MAX, 1'b0),
            cfg_row(REG_DESIRED_LEVEL, 24'd0),
            cfg_row(REG_INITIAL_GAIN, 24'h010000),
            // Large negative error drives the gain down to zero.
            item_row(SMP_MAX, 1'b1, 1'b0),
            item_row(SMP_MIN, 1'b0, 1'b0),
            known_row(SMP_MIN, 1'b0, 1'b1, 0, 0, 1'b0),
            cfg_row(REG_UNUSED, 24'hFFFFFF),
            cfg_row(REG_LOOP_GAIN, CFG_DATA_W'(LOOP_GAIN_RST)),
            cfg_row(REG_DESIRED_LEVEL, CFG_DATA_W'(LEVEL_RST)),
            cfg_row(REG_INITIAL_GAIN, CFG_DATA_W'(INIT_GAIN_RST)),
            item_row(16'sh5555, 1'b1, 1'b0),
            item_row(-16'sh5556, 1'b0, 1'b1),
            item_row(-32767, 1'b0, 1'b0)
        };

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        send_idle_pct = 18;
        recv_idle_pct = 52;
        for (int r = 0; r < DIR_ROWS; r++) begin
            if (dir_tab[r].is_cfg) begin
                drain(LATENCY_SETTLE);
                reg_write(dir_tab[r].idx, dir_tab[r].data);
                settings_used++;
            end else begin
                push_item(dir_tab[r].smp, dir_tab[r].reload, dir_tab[r].last, dir_tab[r]);
            end
        end

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            drain(LATENCY_SETTLE);
            case (ph)
                0, 1: begin
                    send_idle_pct = 18;
                    recv_idle_pct = 52;
                end
                2, 3: begin
                    send_idle_pct = 52;
                    recv_idle_pct = 18;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            case (ph)
                0: begin
                    reg_write(REG_LOOP_GAIN, CFG_DATA_W'(LOOP_GAIN_RST));
                    reg_write(REG_DESIRED_LEVEL, CFG_DATA_W'(LEVEL_RST));
                    reg_write(REG_INITIAL_GAIN, CFG_DATA_W'(INIT_GAIN_RST));
                end
                1: begin
                    reg_write(REG_LOOP_GAIN, 24'hFFFFFF);
                    reg_write(REG_DESIRED_LEVEL, 24'hFFFFFF);
                    reg_write(REG_INITIAL_GAIN, 24'hFFFFFF);
                end
                2: begin
                    reg_write(REG_LOOP_GAIN, 24'd0);
                    reg_write(REG_DESIRED_LEVEL, 24'd0);
                    reg_write(REG_INITIAL_GAIN, 24'd0);
                end
                default: begin
                    reg_write(REG_LOOP_GAIN, ($urandom_range(3) == 0) ? CFG_DATA_W'($urandom)
                                              : CFG_DATA_W'($urandom_range(0, 8191)));
                    reg_write(REG_DESIRED_LEVEL, CFG_DATA_W'($urandom_range(0, 32767)));
                    reg_write(REG_INITIAL_GAIN, CFG_DATA_W'($urandom_range(0, 24'h3FFFF)));
                end
            endcase
            settings_used++;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                // The output holds off while items keep coming, so the block backs up.
                if (ph == 1 && n == 100)
                    hold_req++;
                if (ph == 3 && n == 150)
                    drain(0);
                push_item(random_sample(), ($urandom_range(99) < 4),
                          ($urandom_range(7) == 0), none);
            end
        end

        drain(LATENCY_SETTLE);
        $display("Checked %0d results from %0d items over %0d register settings.",
                 results_checked, items_sent, settings_used);
        $display("Run included reloads, output saturation, gain clamping and a long output hold.");
        if (failures == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
